### hdl/spa_pkg.sv
// Shared types and constants for the sparse polynomial add/subtract unit.
package spa_pkg;

  localparam int MAX_TERMS = 16;
  localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int MODE_W    = 3;
  localparam int COEFF_W   = 16;
  localparam int EXP_W     = 10;
  localparam int RCOEFF_W  = COEFF_W + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_FIRST  = 3'd0,
    MODE_LOAD_SECOND = 3'd1,
    MODE_ADD         = 3'd2,
    MODE_SUB         = 3'd3,
    MODE_CLEAR       = 3'd4
  } mode_t;

  typedef struct packed {
    logic signed [COEFF_W-1:0] coeff;
    logic [EXP_W-1:0]          exponent;
  } term_t;

  typedef struct packed {
    logic load_first;
    logic load_second;
    logic clear;
    logic start;
    logic subtract;
    logic step;
  } spa_cmd_t;

  typedef struct packed {
    logic out_free;
    logic last_step;
  } spa_stat_t;

endpackage

### hdl/spa_if.sv
// Valid/ready word channels for input terms and result terms.
interface spa_in_if;
  import spa_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic signed [COEFF_W-1:0] term_coeff;
  logic [EXP_W-1:0]          term_exponent;
  modport source (output valid, output mode, output term_coeff, output term_exponent,
                  input ready);
  modport sink (input valid, input mode, input term_coeff, input term_exponent,
                output ready);
endinterface

interface spa_out_if;
  import spa_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [RCOEFF_W-1:0] result_coeff;
  logic [EXP_W-1:0]           result_exponent;
  logic                       last_term;
  logic                       empty_result;
  logic                       overflow_seen;
  modport source (output valid, output result_coeff, output result_exponent,
                  output last_term, output empty_result, output overflow_seen,
                  input ready);
  modport sink (input valid, input result_coeff, input result_exponent,
                input last_term, input empty_result, input overflow_seen,
                output ready);
endinterface

### hdl/spa_ctrl.sv
// Controller state machine: decodes input words and sequences the merge.
module spa_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [spa_pkg::MODE_W-1:0] in_mode,
  output logic                      in_ready,
  input  spa_pkg::spa_stat_t        stat,
  output spa_pkg::spa_cmd_t         cmd
);
  import spa_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            MODE_LOAD_FIRST:  cmd.load_first  = 1'b1;
            MODE_LOAD_SECOND: cmd.load_second = 1'b1;
            MODE_ADD: begin
              cmd.start = 1'b1;
              state_nxt = ST_MERGE;
            end
            MODE_SUB: begin
              cmd.start    = 1'b1;
              cmd.subtract = 1'b1;
              state_nxt    = ST_MERGE;
            end
            MODE_CLEAR:       cmd.clear = 1'b1;
            default: ;
          endcase
        end
      end
      ST_MERGE: begin
        cmd.step = stat.out_free;
        if (stat.out_free && stat.last_step) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hdl/spa_dp.sv
// Datapath: term stores, counts, merge indices, combine logic and output register.
module spa_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  spa_pkg::spa_cmd_t                 cmd,
  output spa_pkg::spa_stat_t                stat,
  input  logic signed [spa_pkg::COEFF_W-1:0] in_coeff,
  input  logic [spa_pkg::EXP_W-1:0]         in_exponent,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [spa_pkg::RCOEFF_W-1:0] out_coeff,
  output logic [spa_pkg::EXP_W-1:0]         out_exponent,
  output logic                              out_last,
  output logic                              out_empty,
  output logic                              out_overflow
);
  import spa_pkg::*;

  term_t first_mem  [MAX_TERMS];
  term_t second_mem [MAX_TERMS];

  logic [CNT_W-1:0] first_count_r, second_count_r;
  logic [CNT_W-1:0] i_r, j_r, i_nxt, j_nxt;
  logic             overflow_r;
  logic             sub_r;
  logic             out_valid_r;
  logic signed [RCOEFF_W-1:0] out_coeff_r, res_coeff;
  logic [EXP_W-1:0] out_exp_r, res_exp;
  logic             out_last_r, out_empty_r, out_ovf_r;
  logic             first_full, second_full;
  logic             a_ok, b_ok, res_empty;
  term_t            a_term, b_term;
  logic signed [RCOEFF_W-1:0] a_ext, b_ext;

  assign first_full  = (first_count_r == CNT_W'(MAX_TERMS));
  assign second_full = (second_count_r == CNT_W'(MAX_TERMS));

  assign a_ok   = (i_r < first_count_r);
  assign b_ok   = (j_r < second_count_r);
  assign a_term = first_mem[i_r[IDX_W-1:0]];
  assign b_term = second_mem[j_r[IDX_W-1:0]];
  assign a_ext  = RCOEFF_W'(a_term.coeff);
  assign b_ext  = RCOEFF_W'(b_term.coeff);

  always_comb begin
    i_nxt     = i_r;
    j_nxt     = j_r;
    res_empty = 1'b0;
    res_coeff = '0;
    res_exp   = '0;
    priority if (!a_ok && !b_ok) begin
      res_empty = 1'b1;
    end else if (a_ok && b_ok && (a_term.exponent == b_term.exponent)) begin
      res_coeff = sub_r ? (a_ext - b_ext) : (a_ext + b_ext);
      res_exp   = a_term.exponent;
      i_nxt     = i_r + 1'b1;
      j_nxt     = j_r + 1'b1;
    end else if (!b_ok || (a_ok && (a_term.exponent > b_term.exponent))) begin
      res_coeff = a_ext;
      res_exp   = a_term.exponent;
      i_nxt     = i_r + 1'b1;
    end else begin
      res_coeff = sub_r ? (RCOEFF_W'(0) - b_ext) : b_ext;
      res_exp   = b_term.exponent;
      j_nxt     = j_r + 1'b1;
    end
  end

  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.last_step = (i_nxt >= first_count_r) && (j_nxt >= second_count_r);

  always_ff @(posedge clk) begin
    if (cmd.load_first && !first_full) begin
      first_mem[first_count_r[IDX_W-1:0]] <= '{coeff: in_coeff, exponent: in_exponent};
    end
    if (cmd.load_second && !second_full) begin
      second_mem[second_count_r[IDX_W-1:0]] <= '{coeff: in_coeff, exponent: in_exponent};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_count_r  <= '0;
      second_count_r <= '0;
      overflow_r     <= 1'b0;
      i_r            <= '0;
      j_r            <= '0;
      sub_r          <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cmd.clear) begin
        first_count_r  <= '0;
        second_count_r <= '0;
      end
      if (cmd.load_first) begin
        if (first_full) begin
          overflow_r <= 1'b1;
        end else begin
          first_count_r <= first_count_r + 1'b1;
        end
      end
      if (cmd.load_second) begin
        if (second_full) begin
          overflow_r <= 1'b1;
        end else begin
          second_count_r <= second_count_r + 1'b1;
        end
      end
      if (cmd.start) begin
        i_r   <= '0;
        j_r   <= '0;
        sub_r <= cmd.subtract;
      end else if (cmd.step) begin
        i_r <= i_nxt;
        j_r <= j_nxt;
      end
      if (cmd.step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_coeff_r <= res_coeff;
      out_exp_r   <= res_exp;
      out_last_r  <= stat.last_step;
      out_empty_r <= res_empty;
      out_ovf_r   <= overflow_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_coeff    = out_coeff_r;
  assign out_exponent = out_exp_r;
  assign out_last     = out_last_r;
  assign out_empty    = out_empty_r;
  assign out_overflow = out_ovf_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (first_count_r <= CNT_W'(MAX_TERMS)) && (second_count_r <= CNT_W'(MAX_TERMS)))
    else $error("term count exceeds store depth");
  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (i_r <= first_count_r) && (j_r <= second_count_r))
    else $error("merge index ran past its count");
  a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    overflow_r |=> overflow_r)
    else $error("overflow flag dropped without reset");
  a_step_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (!out_valid_r || out_ready))
    else $error("merge step overwrote a pending result word");
`endif

endmodule

### hdl/sparse_polynomial_add_sub_unit.sv
// Top level of the sparse polynomial add/subtract unit.
//
//   Channel   Direction  Word
//   in_bus    sink       mode, term_coeff, term_exponent
//   out_bus   source     result_coeff, result_exponent, last_term, empty_result,
//                        overflow_seen
//
// Load, clear and unused-mode words are accepted only in the idle state.
// An add or subtract word is accepted while idle, then the merge step emits one result word per
// cycle while the output register is free, max(1, n1 + n2 - matches) words in total.
// The merge step is held while the output register holds a word not yet taken.
// Reset is synchronous and empties both stores and clears the overflow flag.
module sparse_polynomial_add_sub_unit (
  input logic      clk,
  input logic      rst_n,
  spa_in_if.sink   in_bus,
  spa_out_if.source out_bus
);
  import spa_pkg::*;

  spa_cmd_t  cmd;
  spa_stat_t stat;

  spa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_mode  (in_bus.mode),
    .in_ready (in_bus.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spa_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_coeff     (in_bus.term_coeff),
    .in_exponent  (in_bus.term_exponent),
    .out_valid    (out_bus.valid),
    .out_ready    (out_bus.ready),
    .out_coeff    (out_bus.result_coeff),
    .out_exponent (out_bus.result_exponent),
    .out_last     (out_bus.last_term),
    .out_empty    (out_bus.empty_result),
    .out_overflow (out_bus.overflow_seen)
  );

endmodule
